>>> rtl/g711_pkg.sv
// g711_pkg: shared types and constants of the g711 companding converter
// direction codes, register indexes, law masks and the encoder result struct
// no dependencies
`timescale 1ns / 1ps

package g711_pkg;

  // direction codes held in the direction register
  typedef enum logic [1:0] {
    DIR_ENCODE    = 2'd0,
    DIR_DECODE    = 2'd1,
    DIR_TRANSCODE = 2'd2
  } g711_dir_t;

  // configuration register indexes
  localparam logic REG_LAW_SELECT = 1'b0;
  localparam logic REG_DIRECTION  = 1'b1;

  // law select values
  localparam logic LAW_A = 1'b0;
  localparam logic LAW_U = 1'b1;

  // code masks: a-law even-bit inversion with sign, u-law complement with sign
  localparam logic [7:0] A_MASK_POS = 8'hD5;
  localparam logic [7:0] A_MASK_NEG = 8'h55;
  localparam logic [7:0] U_MASK_POS = 8'hFF;
  localparam logic [7:0] U_MASK_NEG = 8'h7F;

  // u-law bias and a-law offsets
  localparam logic [15:0] U_BIAS       = 16'd132;
  localparam logic [15:0] A_SEG_OFFSET = 16'h0108;
  localparam logic [15:0] A_SEG0_ROUND = 16'd8;

  // encoder result
  typedef struct packed {
    logic [7:0] code;
    logic       sat;
  } g711_enc_res_t;

endpackage

>>> rtl/g711_encoder.sv
// g711_encoder: linear sample to a-law or u-law code, with saturation flag
// depends on g711_pkg
`timescale 1ns / 1ps

module g711_encoder import g711_pkg::*; (
  input  logic                law_select,
  input  logic signed [15:0]  linear_sample,
  output g711_enc_res_t       res
);

  // upper ends of the eight segments
  localparam logic [15:0] SEG_TOP [8] = '{
    16'd255, 16'd511, 16'd1023, 16'd2047, 16'd4095, 16'd8191, 16'd16383, 16'd32767
  };

  logic        neg;
  logic [16:0] neg_mag;
  logic [15:0] mag;
  logic [7:0]  mask;
  logic [3:0]  seg;
  logic        found;
  logic [3:0]  shamt;
  logic [15:0] shifted;

  // magnitude and mask per law and sign
  always_comb begin
    neg     = linear_sample[15];
    neg_mag = 17'd0 - {linear_sample[15], linear_sample};
    if (law_select == LAW_A) begin
      if (!neg) begin
        mag  = linear_sample;
        mask = A_MASK_POS;
      end else begin
        // tiny negative samples clamp to zero
        mag  = (neg_mag >= {1'b0, A_SEG0_ROUND}) ?
               16'(neg_mag - {1'b0, A_SEG0_ROUND}) : 16'd0;
        mask = A_MASK_NEG;
      end
    end else begin
      if (neg) begin
        mag  = 16'(neg_mag + {1'b0, U_BIAS});
        mask = U_MASK_NEG;
      end else begin
        mag  = linear_sample + U_BIAS;
        mask = U_MASK_POS;
      end
    end
  end

  // segment search over eight parallel compares
  always_comb begin
    seg   = 4'd8;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!found && (SEG_TOP[i] >= mag)) begin
        seg   = 4'(i);
        found = 1'b1;
      end
    end
  end

  // quantize and build the code
  always_comb begin
    shamt   = (law_select == LAW_A && seg < 4'd2) ? 4'd4 : seg + 4'd3;
    shifted = mag >> shamt;
    if (!found) begin
      res.code = 8'h7F ^ mask;
      res.sat  = 1'b1;
    end else begin
      res.code = {1'b0, seg[2:0], shifted[3:0]} ^ mask;
      res.sat  = 1'b0;
    end
  end

endmodule

>>> rtl/g711_decoder.sv
// g711_decoder: a-law or u-law code to signed linear sample
// depends on g711_pkg
`timescale 1ns / 1ps

module g711_decoder import g711_pkg::*; (
  input  logic               law_select,
  input  logic [7:0]         code_in,
  output logic signed [15:0] linear
);

  logic [7:0]  va;
  logic [7:0]  vu;
  logic [15:0] ta_base;
  logic [15:0] ta;
  logic [15:0] tu;
  logic [15:0] a_lin;
  logic [15:0] u_lin;

  // a-law expansion
  always_comb begin
    va      = code_in ^ A_MASK_NEG;
    ta_base = {8'd0, va[3:0], 4'd0};
    if (va[6:4] == 3'd0) begin
      ta = ta_base + A_SEG0_ROUND;
    end else begin
      ta = (ta_base + A_SEG_OFFSET) << (va[6:4] - 3'd1);
    end
    a_lin = va[7] ? ta : 16'd0 - ta;
  end

  // u-law expansion
  always_comb begin
    vu    = ~code_in;
    tu    = ({9'd0, vu[3:0], 3'd0} + U_BIAS) << vu[6:4];
    u_lin = vu[7] ? U_BIAS - tu : tu - U_BIAS;
  end

  assign linear = (law_select == LAW_A) ? a_lin : u_lin;

endmodule

>>> rtl/g711_transcoder.sv
// g711_transcoder: code of one law straight to the code of the other law
// depends on g711_pkg; holds the 128-entry conversion tables
`timescale 1ns / 1ps

module g711_transcoder import g711_pkg::*; (
  input  logic       law_select,
  input  logic [7:0] code_in,
  output logic [7:0] code_out
);

  localparam logic [7:0] A_TO_U [128] = '{
    8'd1,   8'd3,   8'd5,   8'd7,   8'd9,   8'd11,  8'd13,  8'd15,
    8'd16,  8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,
    8'd24,  8'd25,  8'd26,  8'd27,  8'd28,  8'd29,  8'd30,  8'd31,
    8'd32,  8'd32,  8'd33,  8'd33,  8'd34,  8'd34,  8'd35,  8'd35,
    8'd36,  8'd37,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
    8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd48,  8'd49,  8'd49,
    8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,
    8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd64,
    8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,
    8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,  8'd79,
    8'd80,  8'd81,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,
    8'd88,  8'd89,  8'd90,  8'd91,  8'd92,  8'd93,  8'd94,  8'd95,
    8'd96,  8'd97,  8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103,
    8'd104, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111,
    8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
    8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127
  };

  localparam logic [7:0] U_TO_A [128] = '{
    8'd1,   8'd1,   8'd2,   8'd2,   8'd3,   8'd3,   8'd4,   8'd4,
    8'd5,   8'd5,   8'd6,   8'd6,   8'd7,   8'd7,   8'd8,   8'd8,
    8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  8'd16,
    8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,  8'd24,
    8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd34,  8'd35,  8'd36,
    8'd37,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,  8'd44,
    8'd46,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
    8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
    8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,
    8'd72,  8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,
    8'd81,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,
    8'd89,  8'd90,  8'd91,  8'd92,  8'd93,  8'd94,  8'd95,  8'd96,
    8'd97,  8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103, 8'd104,
    8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112,
    8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120,
    8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128
  };

  logic [7:0] a_idx;
  logic [7:0] u_idx;
  logic [7:0] a_res;
  logic [7:0] u_res;

  // table index drops the sign; the sign picks the output mask
  always_comb begin
    a_idx = code_in ^ A_MASK_NEG;
    u_idx = ~code_in;
    a_res = A_TO_U[a_idx[6:0]] ^ (code_in[7] ? U_MASK_POS : U_MASK_NEG);
    u_res = (U_TO_A[u_idx[6:0]] - 8'd1) ^ (code_in[7] ? A_MASK_POS : A_MASK_NEG);
    code_out = (law_select == LAW_A) ? a_res : u_res;
  end

endmodule

>>> rtl/g711_companding_converter_top.sv
// g711_companding_converter_top: g711 a-law / u-law encode, decode, transcode
// depends on g711_pkg, g711_encoder, g711_decoder, g711_transcoder
`timescale 1ns / 1ps
//
// usage
//   configuration: write law_select (index 0) and direction (index 1) through
//   cfg_valid / cfg_index / cfg_data; cfg_ready is always high. write only while
//   no item is in flight.
//   input: an item is taken at a clock edge with start high and busy low; busy
//   stays low, so an item may be offered every cycle.
//   output: each result sits on linear_out, code_out and saturated for one
//   cycle with done high. the receiver cannot stall; results never wait.
//   path: an accepted item goes through the input register, the conversion
//   logic and the result register, which raises done.
//   throughput: one item per cycle, set by the single-pass conversion logic.
//   reset: synchronous rst clears both configuration registers to zero (a-law
//   encode) and drops any item in flight.
//
module g711_companding_converter_top import g711_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] linear_sample,
  input  logic [7:0]         code_in,
  output logic               done,
  output logic signed [15:0] linear_out,
  output logic [7:0]         code_out,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_data
);

  logic               law_select;
  logic [1:0]         direction;
  logic               in_valid;
  logic signed [15:0] sample_q;
  logic [7:0]         code_q;
  g711_enc_res_t      enc_res;
  logic signed [15:0] dec_lin;
  logic [7:0]         xc_code;
  logic signed [15:0] linear_next;
  logic [7:0]         code_next;
  logic               sat_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      law_select <= LAW_A;
      direction  <= DIR_ENCODE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LAW_SELECT: law_select <= cfg_data[0];
        REG_DIRECTION:  direction  <= cfg_data;
        default:        law_select <= law_select;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      sample_q <= linear_sample;
      code_q   <= code_in;
    end
  end

  g711_encoder u_enc (
    .law_select    (law_select),
    .linear_sample (sample_q),
    .res           (enc_res)
  );

  g711_decoder u_dec (
    .law_select (law_select),
    .code_in    (code_q),
    .linear     (dec_lin)
  );

  g711_transcoder u_xc (
    .law_select (law_select),
    .code_in    (code_q),
    .code_out   (xc_code)
  );

  // pick the result fields by direction; unused fields are zero
  always_comb begin
    linear_next = 16'sd0;
    code_next   = 8'd0;
    sat_next    = 1'b0;
    case (direction)
      DIR_ENCODE: begin
        code_next = enc_res.code;
        sat_next  = enc_res.sat;
      end
      DIR_DECODE: begin
        linear_next = dec_lin;
      end
      DIR_TRANSCODE: begin
        code_next = xc_code;
      end
      default: begin
        linear_next = 16'sd0;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      linear_out <= linear_next;
      code_out   <= code_next;
      saturated  <= sat_next;
    end
  end

endmodule
